// ----- rtl/aabb_pkg.sv -----
// Shared types, widths and constants for the bounding box block.
// Used by every module under rtl; depends on nothing.
package aabb_pkg;

  localparam int CoordWidth  = 32;
  localparam int CoefWidth   = 16;
  localparam int FracBits    = 12;
  localparam int NumAxes     = 3;
  localparam int RowWidth    = NumAxes * CoefWidth;
  localparam int CfgWidth    = (RowWidth > CoordWidth) ? RowWidth : CoordWidth;
  localparam int CfgIdxWidth = 3;
  localparam int ProdWidth   = CoefWidth + CoordWidth;
  localparam int ShWidth     = ProdWidth - FracBits;
  localparam int SumWidth    = ShWidth + 2;
  localparam int InDataWidth  = ((NumAxes * CoordWidth + 7) / 8) * 8;
  localparam int OutDataWidth = ((2 * NumAxes * CoordWidth + 7) / 8) * 8;
  localparam int FifoDepth   = 4;

  typedef logic signed [CoordWidth-1:0] coord_t;

  localparam coord_t CoordMax = coord_t'({1'b0, {(CoordWidth-1){1'b1}}});
  localparam coord_t CoordMin = coord_t'({1'b1, {(CoordWidth-1){1'b0}}});

  localparam logic [CoefWidth-1:0] CoefOne   = CoefWidth'(1) << FracBits;
  localparam logic [RowWidth-1:0]  RowXReset = RowWidth'(CoefOne);
  localparam logic [RowWidth-1:0]  RowYReset = RowWidth'(CoefOne) << CoefWidth;
  localparam logic [RowWidth-1:0]  RowZReset = RowWidth'(CoefOne) << (2 * CoefWidth);

  typedef enum logic [CfgIdxWidth-1:0] {
    RegRowX,
    RegRowY,
    RegRowZ,
    RegShiftX,
    RegShiftY,
    RegShiftZ
  } cfg_reg_e;

  typedef struct packed {
    logic [NumAxes-1:0][RowWidth-1:0] row;
    coord_t [NumAxes-1:0]             shift;
  } cfg_t;

  typedef struct packed {
    coord_t [NumAxes-1:0] pos;
    logic                 last;
    logic                 empty;
  } vtx_t;

  typedef struct packed {
    coord_t [NumAxes-1:0] world;
    logic                 last;
    logic                 empty;
  } wvtx_t;

  typedef struct packed {
    coord_t [NumAxes-1:0] hi;
    coord_t [NumAxes-1:0] lo;
  } box_t;

endpackage

// ----- rtl/aabb_xform.sv -----
// Front end: affine transform of a local vertex into world space.
// Registered products, then floor, sum and saturate. Uses aabb_pkg.
module aabb_xform (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  aabb_pkg::cfg_t       cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  aabb_pkg::vtx_t       in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output aabb_pkg::wvtx_t      out_o
);

  logic signed [aabb_pkg::ProdWidth-1:0] prod_q [aabb_pkg::NumAxes][aabb_pkg::NumAxes];
  logic                                  valid_q;
  logic                                  last_q;
  logic                                  empty_q;
  logic signed [aabb_pkg::ShWidth-1:0]   term [aabb_pkg::NumAxes][aabb_pkg::NumAxes];
  logic signed [aabb_pkg::SumWidth-1:0]  sum  [aabb_pkg::NumAxes];
  logic                                  take;

  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int r = 0; r < aabb_pkg::NumAxes; r++) begin
        for (int c = 0; c < aabb_pkg::NumAxes; c++) begin
          prod_q[r][c] <= $signed(cfg_i.row[r][c*aabb_pkg::CoefWidth +: aabb_pkg::CoefWidth])
                        * $signed(in_i.pos[c]);
        end
      end
      last_q  <= in_i.last;
      empty_q <= in_i.empty;
    end
  end

  // floor products to Q36.0, add translation, clamp to the coordinate range
  always_comb begin
    out_o.last  = last_q;
    out_o.empty = empty_q;
    for (int r = 0; r < aabb_pkg::NumAxes; r++) begin
      sum[r] = aabb_pkg::SumWidth'($signed(cfg_i.shift[r]));
      for (int c = 0; c < aabb_pkg::NumAxes; c++) begin
        term[r][c] = prod_q[r][c][aabb_pkg::ProdWidth-1:aabb_pkg::FracBits];
        sum[r]     = sum[r] + aabb_pkg::SumWidth'(term[r][c]);
      end
      if (sum[r] > aabb_pkg::SumWidth'(aabb_pkg::CoordMax)) begin
        out_o.world[r] = aabb_pkg::CoordMax;
      end else if (sum[r] < aabb_pkg::SumWidth'(aabb_pkg::CoordMin)) begin
        out_o.world[r] = aabb_pkg::CoordMin;
      end else begin
        out_o.world[r] = aabb_pkg::coord_t'(sum[r]);
      end
    end
  end

  assign out_valid_o = valid_q;

endmodule

// ----- rtl/aabb_fifo.sv -----
// Short queue of world-space vertices between front and back ends.
// Register storage, one read port. Uses aabb_pkg.
module aabb_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  aabb_pkg::wvtx_t  in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output aabb_pkg::wvtx_t  out_o
);

  localparam int PtrWidth = (aabb_pkg::FifoDepth > 1) ? $clog2(aabb_pkg::FifoDepth) : 1;
  localparam int CntWidth = $clog2(aabb_pkg::FifoDepth + 1);

  aabb_pkg::wvtx_t     mem_q [aabb_pkg::FifoDepth];
  logic [PtrWidth-1:0] wptr_q, wptr_d;
  logic [PtrWidth-1:0] rptr_q, rptr_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic                push;
  logic                pop;

  assign in_ready_o  = count_q != CntWidth'(aabb_pkg::FifoDepth);
  assign out_valid_o = count_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_o       = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == PtrWidth'(aabb_pkg::FifoDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrWidth'(aabb_pkg::FifoDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_i;
    end
  end

endmodule

// ----- rtl/aabb_track.sv -----
// Back end: running min/max trackers and the registered box output.
// Re-arms on the last vertex or an empty set. Uses aabb_pkg.
module aabb_track (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  aabb_pkg::wvtx_t  in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output aabb_pkg::box_t   out_o
);

  aabb_pkg::coord_t [aabb_pkg::NumAxes-1:0] run_min_q, run_min_d;
  aabb_pkg::coord_t [aabb_pkg::NumAxes-1:0] run_max_q, run_max_d;
  aabb_pkg::box_t                           box_q;
  logic                                     out_valid_q;
  logic                                     emit;
  logic                                     take;

  assign emit       = in_i.last || in_i.empty;
  assign in_ready_o = !emit || !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    for (int a = 0; a < aabb_pkg::NumAxes; a++) begin
      run_min_d[a] = ($signed(in_i.world[a]) < $signed(run_min_q[a])) ? in_i.world[a]
                                                                     : run_min_q[a];
      run_max_d[a] = ($signed(in_i.world[a]) > $signed(run_max_q[a])) ? in_i.world[a]
                                                                     : run_max_q[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_min_q   <= {aabb_pkg::NumAxes{aabb_pkg::CoordMax}};
      run_max_q   <= {aabb_pkg::NumAxes{aabb_pkg::CoordMin}};
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        if (emit) begin
          run_min_q <= {aabb_pkg::NumAxes{aabb_pkg::CoordMax}};
          run_max_q <= {aabb_pkg::NumAxes{aabb_pkg::CoordMin}};
        end else begin
          run_min_q <= run_min_d;
          run_max_q <= run_max_d;
        end
      end
      if (take && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      if (in_i.empty) begin
        box_q <= '0;
      end else begin
        box_q.lo <= run_min_d;
        box_q.hi <= run_max_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = box_q;

endmodule

// ----- rtl/aabb_from_transformed_vertices_top.sv -----
// Top level: configuration registers, transform front end, queue, tracker back end.
// Depends on aabb_pkg, aabb_xform, aabb_fifo and aabb_track.
//
//   port group     dir   carries
//   s_axis_*       in    local vertex pos_x/y/z, tlast = last_vertex, tuser = empty_set
//   m_axis_*       out   box min_x/y/z, max_x/y/z
//   cfg_*          in    register writes, index per register list, no read-back
//
// One vertex per cycle sustained while the box output is not stalled; the tracker
// compare is the only recurrence. After its last vertex is accepted, a box passes
// through the product register, the queue entry and the box output register.
// Reset restores the identity matrix, zero translation and re-armed trackers.
// A four-entry queue decouples the transform from output stalls.
module aabb_from_transformed_vertices_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [aabb_pkg::InDataWidth-1:0]    s_axis_tdata,   // pos_x, pos_y, pos_z
  input  logic                                s_axis_tlast,
  input  logic                                s_axis_tuser,   // empty_set
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [aabb_pkg::OutDataWidth-1:0]   m_axis_tdata,   // min_x, min_y, min_z,
                                                              // max_x, max_y, max_z
  input  logic                                cfg_we_i,
  input  logic [aabb_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [aabb_pkg::CfgWidth-1:0]       cfg_data_i
);

  aabb_pkg::cfg_t  cfg_q;
  aabb_pkg::vtx_t  vtx;
  aabb_pkg::wvtx_t xf_out;
  aabb_pkg::wvtx_t q_out;
  aabb_pkg::box_t  box;
  logic            xf_valid, q_ready;
  logic            q_valid, trk_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row[0] <= aabb_pkg::RowXReset;
      cfg_q.row[1] <= aabb_pkg::RowYReset;
      cfg_q.row[2] <= aabb_pkg::RowZReset;
      cfg_q.shift  <= '0;
    end else if (cfg_we_i) begin
      unique case (aabb_pkg::cfg_reg_e'(cfg_index_i))
        aabb_pkg::RegRowX:   cfg_q.row[0]   <= cfg_data_i[aabb_pkg::RowWidth-1:0];
        aabb_pkg::RegRowY:   cfg_q.row[1]   <= cfg_data_i[aabb_pkg::RowWidth-1:0];
        aabb_pkg::RegRowZ:   cfg_q.row[2]   <= cfg_data_i[aabb_pkg::RowWidth-1:0];
        aabb_pkg::RegShiftX: cfg_q.shift[0] <= cfg_data_i[aabb_pkg::CoordWidth-1:0];
        aabb_pkg::RegShiftY: cfg_q.shift[1] <= cfg_data_i[aabb_pkg::CoordWidth-1:0];
        aabb_pkg::RegShiftZ: cfg_q.shift[2] <= cfg_data_i[aabb_pkg::CoordWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < aabb_pkg::NumAxes; a++) begin
      vtx.pos[a] = s_axis_tdata[a*aabb_pkg::CoordWidth +: aabb_pkg::CoordWidth];
    end
    vtx.last  = s_axis_tlast;
    vtx.empty = s_axis_tuser;
  end

  aabb_xform u_xform (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_i        (vtx),
    .out_valid_o (xf_valid),
    .out_ready_i (q_ready),
    .out_o       (xf_out)
  );

  aabb_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (xf_valid),
    .in_ready_o  (q_ready),
    .in_i        (xf_out),
    .out_valid_o (q_valid),
    .out_ready_i (trk_ready),
    .out_o       (q_out)
  );

  aabb_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (trk_ready),
    .in_i        (q_out),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (box)
  );

  assign m_axis_tdata = aabb_pkg::OutDataWidth'(box);

  a_accept_fills_front : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> xf_valid)
    else $error("accepted vertex did not reach the product stage");

  a_front_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    xf_valid && !q_ready |=> xf_valid)
    else $error("front stage dropped a vertex while the queue was full");

  a_empty_zero_box : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && trk_ready && q_out.empty |=> m_axis_tvalid && (m_axis_tdata == '0))
    else $error("empty set did not produce a zero box");

endmodule

// ----- verif/tb_aabb_from_transformed_vertices_top.sv -----
// Self-checking testbench for the transformed-vertex bounding box block. Streams
// directed and random vertex sets through several matrix settings and checks every
// box against a predictor or a directed-table box; depends on aabb_pkg and the top level.
`timescale 1ns / 1ps

module tb_aabb_from_transformed_vertices_top;

  localparam int ResetCycles = 4;
  localparam int DrainCycles = 8;
  localparam int StallLimit  = 4000;
  localparam int PhaseItems  = 240;
  localparam int NumPhases   = 8;
  localparam int HoldCycles  = 300;
  localparam int IdlePercent = 34;

  localparam logic [aabb_pkg::CfgIdxWidth-1:0] RegSpareA =
    aabb_pkg::CfgIdxWidth'(int'(aabb_pkg::RegShiftZ) + 1);
  localparam logic [aabb_pkg::CfgIdxWidth-1:0] RegSpareB =
    aabb_pkg::CfgIdxWidth'(int'(aabb_pkg::RegShiftZ) + 2);

  typedef struct {
    aabb_pkg::coord_t x;
    aabb_pkg::coord_t y;
    aabb_pkg::coord_t z;
    logic             last;
    logic             empty;
    logic             typed;
    aabb_pkg::box_t   box;
  } vtx_row_t;

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [aabb_pkg::InDataWidth-1:0]  s_axis_tdata  = '0;   // pos_x, pos_y, pos_z
  logic                              s_axis_tlast  = 1'b0;
  logic                              s_axis_tuser  = 1'b0; // empty_set
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [aabb_pkg::OutDataWidth-1:0] m_axis_tdata;   // min_x, min_y, min_z,
                                                     // max_x, max_y, max_z
  logic                              cfg_we_i      = 1'b0;
  logic [aabb_pkg::CfgIdxWidth-1:0]  cfg_index_i   = '0;
  logic [aabb_pkg::CfgWidth-1:0]     cfg_data_i    = '0;

  logic [aabb_pkg::RowWidth-1:0] mdl_row   [aabb_pkg::NumAxes];
  aabb_pkg::coord_t              mdl_shift [aabb_pkg::NumAxes];
  aabb_pkg::coord_t              trk_lo    [aabb_pkg::NumAxes];
  aabb_pkg::coord_t              trk_hi    [aabb_pkg::NumAxes];
  aabb_pkg::box_t                box_q     [$];

  int    errors        = 0;
  int    vtx_sent      = 0;
  int    boxes_checked = 0;
  int    stall_cnt     = 0;
  int    hold_left     = 0;
  bit    hold_req      = 1'b0;
  bit    src_idle_en   = 1'b1;
  bit    snk_idle_en   = 1'b1;
  string axis_nm [aabb_pkg::NumAxes] = '{"x", "y", "z"};

  aabb_from_transformed_vertices_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic aabb_pkg::coord_t world_coord(logic [aabb_pkg::RowWidth-1:0] row,
                                                   aabb_pkg::coord_t shift,
                                                   aabb_pkg::coord_t x,
                                                   aabb_pkg::coord_t y,
                                                   aabb_pkg::coord_t z);
    longint acc;
    acc = longint'(shift)
        + ((longint'($signed(row[aabb_pkg::CoefWidth-1:0])) * longint'(x))
           >>> aabb_pkg::FracBits)
        + ((longint'($signed(row[2*aabb_pkg::CoefWidth-1:aabb_pkg::CoefWidth]))
            * longint'(y)) >>> aabb_pkg::FracBits)
        + ((longint'($signed(row[aabb_pkg::RowWidth-1:2*aabb_pkg::CoefWidth]))
            * longint'(z)) >>> aabb_pkg::FracBits);
    if (acc > longint'(aabb_pkg::CoordMax)) return aabb_pkg::CoordMax;
    if (acc < longint'(aabb_pkg::CoordMin)) return aabb_pkg::CoordMin;
    return aabb_pkg::coord_t'(acc);
  endfunction

  function automatic void rearm_trackers();
    for (int a = 0; a < aabb_pkg::NumAxes; a++) begin
      trk_lo[a] = aabb_pkg::CoordMax;
      trk_hi[a] = aabb_pkg::CoordMin;
    end
  endfunction

  function automatic bit predict_box(aabb_pkg::coord_t x, aabb_pkg::coord_t y,
                                     aabb_pkg::coord_t z, logic last,
                                     logic empty, output aabb_pkg::box_t b);
    aabb_pkg::coord_t w [aabb_pkg::NumAxes];
    b = '0;
    if (empty) begin
      rearm_trackers();
      return 1'b1;
    end
    for (int a = 0; a < aabb_pkg::NumAxes; a++) begin
      w[a] = world_coord(mdl_row[a], mdl_shift[a], x, y, z);
      if (w[a] < trk_lo[a]) trk_lo[a] = w[a];
      if (w[a] > trk_hi[a]) trk_hi[a] = w[a];
    end
    if (!last) return 1'b0;
    for (int a = 0; a < aabb_pkg::NumAxes; a++) begin
      b.lo[a] = trk_lo[a];
      b.hi[a] = trk_hi[a];
    end
    rearm_trackers();
    return 1'b1;
  endfunction

  function automatic aabb_pkg::box_t mk_box(aabb_pkg::coord_t lx, aabb_pkg::coord_t ly,
                                            aabb_pkg::coord_t lz, aabb_pkg::coord_t hx,
                                            aabb_pkg::coord_t hy, aabb_pkg::coord_t hz);
    aabb_pkg::box_t b;
    b.lo[0] = lx; b.lo[1] = ly; b.lo[2] = lz;
    b.hi[0] = hx; b.hi[1] = hy; b.hi[2] = hz;
    return b;
  endfunction

  function automatic vtx_row_t vrow(aabb_pkg::coord_t x, aabb_pkg::coord_t y,
                                    aabb_pkg::coord_t z, logic last,
                                    logic empty, logic typed, aabb_pkg::box_t b);
    vtx_row_t r;
    r.x = x; r.y = y; r.z = z;
    r.last = last; r.empty = empty; r.typed = typed; r.box = b;
    return r;
  endfunction

  function automatic aabb_pkg::coord_t rand_coord();
    case ($urandom_range(9))
      0: return aabb_pkg::CoordMax;
      1: return aabb_pkg::CoordMin;
      2: return '0;
      3: return aabb_pkg::coord_t'(-1);
      4: return aabb_pkg::coord_t'($urandom_range(131071)) - aabb_pkg::coord_t'(65536);
      default: return aabb_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [aabb_pkg::CoefWidth-1:0] pick_coef();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return aabb_pkg::CoefOne;
      3: return '0;
      4: return -aabb_pkg::CoefOne;
      default: return aabb_pkg::CoefWidth'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic cfg_write(logic [aabb_pkg::CfgIdxWidth-1:0] idx,
                           logic [aabb_pkg::CfgWidth-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    case (idx)
      aabb_pkg::RegRowX:   mdl_row[0]   = d[aabb_pkg::RowWidth-1:0];
      aabb_pkg::RegRowY:   mdl_row[1]   = d[aabb_pkg::RowWidth-1:0];
      aabb_pkg::RegRowZ:   mdl_row[2]   = d[aabb_pkg::RowWidth-1:0];
      aabb_pkg::RegShiftX: mdl_shift[0] = d[aabb_pkg::CoordWidth-1:0];
      aabb_pkg::RegShiftY: mdl_shift[1] = d[aabb_pkg::CoordWidth-1:0];
      aabb_pkg::RegShiftZ: mdl_shift[2] = d[aabb_pkg::CoordWidth-1:0];
      default: ;
    endcase
  endtask

  task automatic send_vertex(aabb_pkg::coord_t x, aabb_pkg::coord_t y,
                             aabb_pkg::coord_t z, logic last, logic empty,
                             logic typed, aabb_pkg::box_t tbox);
    bit             took;
    aabb_pkg::box_t pbox;
    while (src_idle_en && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    s_axis_tlast  <= last;
    s_axis_tuser  <= empty;
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
    vtx_sent++;
    if (predict_box(x, y, z, last, empty, pbox)) box_q.push_back(typed ? tbox : pbox);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (box_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_matrix(int p);
    logic [aabb_pkg::RowWidth-1:0] rows [aabb_pkg::NumAxes];
    aabb_pkg::coord_t              sh   [aabb_pkg::NumAxes];
    for (int a = 0; a < aabb_pkg::NumAxes; a++) begin
      case (p)
        0: begin
          rows[a] = {aabb_pkg::NumAxes{16'h7FFF}};
          sh[a]   = aabb_pkg::CoordMax;
        end
        1: begin
          rows[a] = {aabb_pkg::NumAxes{16'h8000}};
          sh[a]   = aabb_pkg::CoordMin;
        end
        2: begin
          rows[a] = '0;
          sh[a]   = rand_coord();
        end
        4, 7: begin
          rows[a] = {pick_coef(), pick_coef(), pick_coef()};
          sh[a]   = rand_coord();
        end
        5: begin
          rows[a] = aabb_pkg::RowWidth'(aabb_pkg::CoefOne) << (a * aabb_pkg::CoefWidth);
          sh[a]   = aabb_pkg::coord_t'($urandom);
        end
        default: begin
          rows[a] = aabb_pkg::RowWidth'({$urandom, $urandom});
          sh[a]   = aabb_pkg::coord_t'($urandom);
        end
      endcase
    end
    cfg_write(aabb_pkg::RegRowX,   aabb_pkg::CfgWidth'(rows[0]));
    cfg_write(aabb_pkg::RegRowY,   aabb_pkg::CfgWidth'(rows[1]));
    cfg_write(aabb_pkg::RegRowZ,   aabb_pkg::CfgWidth'(rows[2]));
    cfg_write(aabb_pkg::RegShiftX,
              {(aabb_pkg::CfgWidth-aabb_pkg::CoordWidth)'($urandom), sh[0]});
    cfg_write(aabb_pkg::RegShiftY,
              {(aabb_pkg::CfgWidth-aabb_pkg::CoordWidth)'($urandom), sh[1]});
    cfg_write(aabb_pkg::RegShiftZ,
              {(aabb_pkg::CfgWidth-aabb_pkg::CoordWidth)'($urandom), sh[2]});
    if (p == 5) begin
      cfg_write(RegSpareA, aabb_pkg::CfgWidth'({$urandom, $urandom}));
      cfg_write(RegSpareB, aabb_pkg::CfgWidth'({$urandom, $urandom}));
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 5) begin
        send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(1)), 1'b1,
                    1'b0, '0);
        sent++;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          send_vertex(rand_coord(), rand_coord(), rand_coord(), i == len - 1, 1'b0, 1'b0,
                      '0);
        sent += len;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(snk_idle_en && $urandom_range(99) < IdlePercent);
    end
  end

  always @(negedge clk_i) begin
    aabb_pkg::box_t got;
    aabb_pkg::box_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = aabb_pkg::box_t'(m_axis_tdata);
      if (box_q.size() == 0) begin
        report_mismatch($sformatf("box with nothing expected: %h", m_axis_tdata));
      end else begin
        want = box_q.pop_front();
        boxes_checked++;
        for (int a = 0; a < aabb_pkg::NumAxes; a++) begin
          if (got.lo[a] !== want.lo[a])
            report_mismatch($sformatf("min_%s got %h want %h", axis_nm[a], got.lo[a],
                                      want.lo[a]));
          if (got.hi[a] !== want.hi[a])
            report_mismatch($sformatf("max_%s got %h want %h", axis_nm[a], got.hi[a],
                                      want.hi[a]));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      stall_cnt = 0;
    else
      stall_cnt++;
    if (stall_cnt >= StallLimit) begin
      $display("Watchdog: no transfer for %0d cycles, %0d boxes outstanding", stall_cnt,
               box_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    vtx_row_t dir_tbl [$];
    mdl_row   = '{aabb_pkg::RowXReset, aabb_pkg::RowYReset, aabb_pkg::RowZReset};
    mdl_shift = '{default: '0};
    rearm_trackers();

    dir_tbl.push_back(vrow(0, 0, 0, 1'b1, 1'b0, 1'b1, mk_box(0, 0, 0, 0, 0, 0)));
    dir_tbl.push_back(vrow(aabb_pkg::CoordMax, aabb_pkg::CoordMin, 1, 1'b1, 1'b0, 1'b1,
                           mk_box(aabb_pkg::CoordMax, aabb_pkg::CoordMin, 1,
                                  aabb_pkg::CoordMax, aabb_pkg::CoordMin, 1)));
    dir_tbl.push_back(vrow(aabb_pkg::CoordMin, aabb_pkg::CoordMax, -1, 1'b1, 1'b0, 1'b1,
                           mk_box(aabb_pkg::CoordMin, aabb_pkg::CoordMax, -1,
                                  aabb_pkg::CoordMin, aabb_pkg::CoordMax, -1)));
    dir_tbl.push_back(vrow(aabb_pkg::CoordMax, aabb_pkg::CoordMax, aabb_pkg::CoordMax,
                           1'b0, 1'b1, 1'b1, '0));
    dir_tbl.push_back(vrow(aabb_pkg::CoordMin, -1, aabb_pkg::CoordMax, 1'b1, 1'b1, 1'b1,
                           '0));
    dir_tbl.push_back(vrow(1, 2, 3, 1'b0, 1'b0, 1'b0, '0));
    dir_tbl.push_back(vrow(-5, 10, 0, 1'b0, 1'b0, 1'b0, '0));
    dir_tbl.push_back(vrow(7, -20, 4, 1'b1, 1'b0, 1'b1, mk_box(-5, -20, 0, 7, 10, 4)));
    dir_tbl.push_back(vrow(100, 100, 100, 1'b0, 1'b0, 1'b0, '0));
    dir_tbl.push_back(vrow(0, 0, 0, 1'b0, 1'b1, 1'b1, '0));
    dir_tbl.push_back(vrow(5, 5, 5, 1'b1, 1'b0, 1'b1, mk_box(5, 5, 5, 5, 5, 5)));
    dir_tbl.push_back(vrow(aabb_pkg::CoordMax, aabb_pkg::CoordMax, aabb_pkg::CoordMax,
                           1'b0, 1'b0, 1'b0, '0));
    dir_tbl.push_back(vrow(aabb_pkg::CoordMin, aabb_pkg::CoordMin, aabb_pkg::CoordMin,
                           1'b0, 1'b0, 1'b0, '0));
    dir_tbl.push_back(vrow(-1, -1, -1, 1'b0, 1'b0, 1'b0, '0));
    dir_tbl.push_back(vrow(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 1'b1, 1'b0, 1'b0,
                           '0));
    dir_tbl.push_back(vrow(32'hAAAA_AAAA, 32'h5555_5555, -65536, 1'b1, 1'b0, 1'b0, '0));
    dir_tbl.push_back(vrow(65536, -65536, 0, 1'b0, 1'b0, 1'b0, '0));
    dir_tbl.push_back(vrow(-65536, 65536, 0, 1'b1, 1'b0, 1'b0, '0));

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i])
      send_vertex(dir_tbl[i].x, dir_tbl[i].y, dir_tbl[i].z, dir_tbl[i].last,
                  dir_tbl[i].empty, dir_tbl[i].typed, dir_tbl[i].box);
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      set_matrix(p);
      if (p == 3) begin
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
      end
      if (p == 4) begin
        @(negedge clk_i);
        hold_req = 1'b1;
        @(posedge clk_i);
      end
      run_random(PhaseItems);
      wait_drained();
      src_idle_en = 1'b1;
      snk_idle_en = 1'b1;
    end

    $display("Run covered %0d vertices across %0d matrix settings", vtx_sent, NumPhases + 1);
    $display("Boxes compared: %0d, mismatches: %0d", boxes_checked, errors);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/aabb_pkg.sv
rtl/aabb_xform.sv
rtl/aabb_fifo.sv
rtl/aabb_track.sv
rtl/aabb_from_transformed_vertices_top.sv
verif/tb_aabb_from_transformed_vertices_top.sv
